FILE: hdl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types, verdict codes and protocol constants of the IPv4 header
// checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam logic [2:0] V_LOCAL    = 3'd0;
    localparam logic [2:0] V_FORWARD  = 3'd1;
    localparam logic [2:0] V_DISABLED = 3'd2;
    localparam logic [2:0] V_SHORT    = 3'd3;
    localparam logic [2:0] V_BADHDR   = 3'd4;
    localparam logic [2:0] V_CSUM     = 3'd5;

    localparam logic [1:0] C_ICMP  = 2'd0;
    localparam logic [1:0] C_TCP   = 2'd1;
    localparam logic [1:0] C_UDP   = 2'd2;
    localparam logic [1:0] C_OTHER = 2'd3;

    localparam logic [7:0] P_ICMP = 8'd1;
    localparam logic [7:0] P_TCP  = 8'd6;
    localparam logic [7:0] P_UDP  = 8'd17;

    localparam logic [15:0] MIN_SIZE   = 16'd20;
    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  MIN_IHL    = 4'd5;

    localparam logic [4:0] IDX_PROTO  = 5'd4;
    localparam logic [4:0] IDX_CSUM   = 5'd5;
    localparam logic [4:0] IDX_DST_HI = 5'd8;
    localparam logic [4:0] IDX_DST_LO = 5'd9;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_LOCAL  = 1'b1;

    localparam logic [31:0] LOCAL_ADDR_RESET = 32'hC0A8_0164;

    typedef struct packed {
        logic [15:0] word;
        logic        sop;
        logic [15:0] size;
    } t_beat;

    typedef struct packed {
        logic        enable;
        logic [31:0] local_addr;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  proto_class;
        logic [7:0]  proto_num;
        logic [15:0] payload_len;
    } t_result;

    function automatic logic [1:0] proto_class_of(input logic [7:0] p);
        logic [1:0] c;
        case (p)
            P_ICMP:  c = C_ICMP;
            P_TCP:   c = C_TCP;
            P_UDP:   c = C_UDP;
            default: c = C_OTHER;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/ihc_apb_regs.sv
// ----------------------------------------------------------------------------
// ihc_apb_regs
// APB register bank: enable bit and local IPv4 address.
// ----------------------------------------------------------------------------
module ihc_apb_regs
    import ihc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic        r_enable;
    logic [31:0] r_local_addr;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_local_addr <= LOCAL_ADDR_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_ENABLE: r_enable     <= pwdata[0];
                REG_LOCAL:  r_local_addr <= pwdata;
                default:    r_enable     <= r_enable;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ENABLE: prdata = {31'd0, r_enable};
            REG_LOCAL:  prdata = r_local_addr;
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.enable     = r_enable;
    assign o_cfg.local_addr = r_local_addr;

endmodule

FILE: hdl/ihc_hdr_core.sv
// ----------------------------------------------------------------------------
// ihc_hdr_core
// Input register plus header state: checks the first word, accumulates the
// ones-complement sum, captures protocol and destination, issues a verdict.
// ----------------------------------------------------------------------------
module ihc_hdr_core
    import ihc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_beat   i_beat,
    input  t_cfg    i_cfg,
    output logic    o_pending,
    output logic    o_res_valid,
    output t_result o_res
);

    logic        r_in_valid;
    t_beat       r_beat;

    logic        r_in_header, n_in_header;
    logic [4:0]  r_idx, n_idx;
    logic [3:0]  r_hw, n_hw;
    logic [20:0] r_sum, n_sum;
    logic [15:0] r_rx_csum, n_rx_csum;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_dest, n_dest;
    logic [15:0] r_size, n_size;

    logic [3:0]  w_version;
    logic [3:0]  w_ihl;
    logic [5:0]  w_next_cnt;
    logic [5:0]  w_limit;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;
    logic [15:0] w_calc;
    logic [15:0] w_hdr_bytes;
    logic [15:0] w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_pending  = r_in_valid;
    assign w_version  = r_beat.word[15:12];
    assign w_ihl      = r_beat.word[11:8];
    assign w_next_cnt = {1'b0, r_idx} + 6'd1;
    assign w_limit    = {1'b0, r_hw, 1'b0};

    assign w_fold1     = {1'b0, n_sum[15:0]} + {12'd0, n_sum[20:16]};
    assign w_fold2     = w_fold1[15:0] + {15'd0, w_fold1[16]};
    assign w_calc      = ~w_fold2;
    assign w_hdr_bytes = {10'd0, r_hw, 2'b00};
    assign w_len       = (r_size >= w_hdr_bytes) ? (r_size - w_hdr_bytes) : 16'd0;

    always_comb begin
        n_in_header = r_in_header;
        n_idx       = r_idx;
        n_hw        = r_hw;
        n_sum       = r_sum;
        n_rx_csum   = r_rx_csum;
        n_proto     = r_proto;
        n_dest      = r_dest;
        n_size      = r_size;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_in_valid) begin
            if (r_beat.sop) begin
                n_in_header = 1'b0;
                if (!i_cfg.enable) begin
                    o_res_valid     = 1'b1;
                    o_res.verdict   = V_DISABLED;
                end else if (r_beat.size < MIN_SIZE) begin
                    o_res_valid     = 1'b1;
                    o_res.verdict   = V_SHORT;
                end else if (w_version != IP_VERSION || w_ihl < MIN_IHL) begin
                    o_res_valid     = 1'b1;
                    o_res.verdict   = V_BADHDR;
                end else begin
                    n_in_header = 1'b1;
                    n_hw        = w_ihl;
                    n_size      = r_beat.size;
                    n_idx       = 5'd1;
                    n_sum       = {5'd0, r_beat.word};
                    n_rx_csum   = 16'd0;
                    n_proto     = 8'd0;
                    n_dest      = 32'd0;
                end
            end else if (r_in_header) begin
                case (r_idx)
                    IDX_PROTO:  n_proto = r_beat.word[7:0];
                    IDX_DST_HI: n_dest  = {r_beat.word, r_dest[15:0]};
                    IDX_DST_LO: n_dest  = {r_dest[31:16], r_beat.word};
                    default:    n_dest  = r_dest;
                endcase
                if (r_idx == IDX_CSUM) begin
                    n_rx_csum = r_beat.word;
                end else begin
                    n_sum = r_sum + {5'd0, r_beat.word};
                end
                if (w_next_cnt < w_limit) begin
                    n_idx = w_next_cnt[4:0];
                end else begin
                    n_idx           = 5'd0;
                    n_in_header     = 1'b0;
                    o_res_valid     = 1'b1;
                    o_res.proto_num = n_proto;
                    if (w_calc != n_rx_csum) begin
                        o_res.verdict = V_CSUM;
                    end else if (n_dest != i_cfg.local_addr) begin
                        o_res.verdict     = V_FORWARD;
                        o_res.payload_len = w_len;
                    end else begin
                        o_res.verdict     = V_LOCAL;
                        o_res.proto_class = proto_class_of(n_proto);
                        o_res.payload_len = w_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
            r_idx       <= 5'd0;
        end else begin
            r_in_header <= n_in_header;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hw      <= n_hw;
        r_sum     <= n_sum;
        r_rx_csum <= n_rx_csum;
        r_proto   <= n_proto;
        r_dest    <= n_dest;
        r_size    <= n_size;
    end

endmodule

FILE: hdl/ihc_out_fifo.sv
// ----------------------------------------------------------------------------
// ihc_out_fifo
// Small result queue that decouples verdict generation from the output
// handshake.
// ----------------------------------------------------------------------------
module ihc_out_fifo
    import ihc_pkg::*;
#(
    parameter int DEPTH = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_result                    i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_result                    o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/ipv4_header_checker_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker_unit
// IPv4 header validation with ones-complement checksum, destination match
// and protocol classification; one verdict per header.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+----------------------
//   header in | input     | i_in_valid / o_in_stall    | word, sop, size
//   verdict   | output    | o_out_valid / i_out_stall  | verdict, class, proto, len
//   config    | input     | APB psel/penable/pready    | enable, local address
//
// One header beat per cycle while o_in_stall is low. A beat passes the input
// register, then the checker logic writes the result queue. Input stalls only
// when the result queue plus the beat in flight fill FIFO_DEPTH entries.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_header_checker_unit
    import ihc_pkg::*;
#(
    parameter int FIFO_DEPTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_header_word,
    input  logic        i_start_of_packet,
    input  logic [15:0] i_packet_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_verdict,
    output logic [1:0]  o_protocol_class,
    output logic [7:0]  o_protocol_number,
    output logic [15:0] o_payload_length
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_cfg          w_cfg;
    t_beat         w_beat;
    t_result       w_res;
    t_result       w_out;
    logic          w_res_valid;
    logic          w_pending;
    logic          w_load;
    logic          w_pop;
    logic [CW-1:0] w_count;
    logic [CW:0]   w_occupancy;

    assign w_beat.word = i_header_word;
    assign w_beat.sop  = i_start_of_packet;
    assign w_beat.size = i_packet_size;

    assign w_occupancy = {1'b0, w_count} + {{CW{1'b0}}, w_pending};
    assign o_in_stall  = (w_occupancy >= (CW + 1)'(FIFO_DEPTH));
    assign w_load      = i_in_valid && !o_in_stall;
    assign w_pop       = o_out_valid && !i_out_stall;

    ihc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ihc_hdr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_beat      (w_beat),
        .i_cfg       (w_cfg),
        .o_pending   (w_pending),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ihc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_verdict         = w_out.verdict;
    assign o_protocol_class  = w_out.proto_class;
    assign o_protocol_number = w_out.proto_num;
    assign o_payload_length  = w_out.payload_len;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count == CW'(FIFO_DEPTH)) |-> !(w_res_valid && !w_pop))
        else $error("result queue overflow");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= V_CSUM))
        else $error("verdict code out of range");

    a_early_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict == V_DISABLED || o_verdict == V_SHORT ||
                         o_verdict == V_BADHDR))
        |-> (o_protocol_number == 8'd0 && o_payload_length == 16'd0))
        else $error("first-word reject carries header fields");

    a_class_local_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict != V_LOCAL) |-> (o_protocol_class == C_ICMP))
        else $error("protocol class set on non-local verdict");

endmodule
